// ----- design/lssg_pkg.sv -----
// ----------------------------------------------------------------------------
// lssg_pkg: shared types and constants of the LED strip segment gradient.
// Holds the request and pixel structs, the precomputed command record and
// the reciprocal table that the pixel datapath uses for exact ramp division.
// ----------------------------------------------------------------------------
package lssg_pkg;

  // Field widths.
  localparam int unsigned CH_W       = 8;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned BOUND_W    = 7;
  localparam int unsigned NUM_BOUNDS = 6;
  localparam int unsigned NUM_COLORS = 3;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned SEG_W      = 3;
  localparam int unsigned CFG_IDX_W  = 3;

  // Default strip length.
  localparam int unsigned STRIP_LEN_DEF = 64;

  // Queue depths; both are powers of two.
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH) + 1;

  // Ramp arithmetic: numerators fit in 15 bits, reciprocals are 2^16 / len.
  localparam int unsigned PROD_W      = 15;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned MUL_W       = PROD_W + RECIP_W;
  localparam int unsigned REM_W       = BOUND_W + 1;
  localparam logic [RECIP_W-1:0] RECIP_ONE = {1'b1, {RECIP_SHIFT{1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOLID_A_END = 3'd0,
    REG_RAMP_AB_END = 3'd1,
    REG_SOLID_B_END = 3'd2,
    REG_RAMP_BC_END = 3'd3,
    REG_SOLID_C_END = 3'd4,
    REG_RAMP_CA_END = 3'd5
  } cfg_reg_e;

  // One request: three RGB colors.
  typedef struct packed {
    logic [CH_W-1:0] a_red;
    logic [CH_W-1:0] a_green;
    logic [CH_W-1:0] a_blue;
    logic [CH_W-1:0] b_red;
    logic [CH_W-1:0] b_green;
    logic [CH_W-1:0] b_blue;
    logic [CH_W-1:0] c_red;
    logic [CH_W-1:0] c_green;
    logic [CH_W-1:0] c_blue;
  } cmd_t;

  // One result pixel.
  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic [CH_W-1:0]  pix_red;
    logic [CH_W-1:0]  pix_green;
    logic [CH_W-1:0]  pix_blue;
    logic             written;
    logic             last_pixel;
  } pixel_t;

  // A color as channels red, green, blue at indexes 0, 1, 2.
  typedef logic [NUM_CH-1:0][CH_W-1:0] color_t;

  // Direction and size of the channel step of one ramp.
  typedef struct packed {
    logic            neg;
    logic [CH_W-1:0] mag;
  } ramp_t;

  // Classified request handed from the front end to the pixel engine.
  typedef struct packed {
    color_t [NUM_COLORS-1:0]              col;
    ramp_t  [NUM_COLORS-1:0][NUM_CH-1:0]  rmp;
  } job_t;

  typedef logic [NUM_BOUNDS-1:0][BOUND_W-1:0] bounds_t;

  typedef logic [2**BOUND_W-1:0][RECIP_W-1:0] recip_tab_t;

  // Builds floor(2^16 / len) for every segment length by long division.
  function automatic recip_tab_t build_recip();
    recip_tab_t         tab;
    logic [RECIP_W-1:0] quo;
    logic [REM_W-1:0]   rem;
    tab = '0;
    for (int l = 1; l < 2**BOUND_W; l++) begin
      rem = '0;
      quo = '0;
      for (int b = RECIP_W - 1; b >= 0; b--) begin
        rem = {rem[REM_W-2:0], RECIP_ONE[b]};
        if (rem >= REM_W'(l)) begin
          rem    = rem - REM_W'(l);
          quo[b] = 1'b1;
        end
      end
      tab[l] = quo;
    end
    return tab;
  endfunction

  localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

// ----- design/lssg_fifo.sv -----
// ----------------------------------------------------------------------------
// lssg_fifo: small synchronous queue.
// Register storage with a first-word-through read port and an occupancy count.
// ----------------------------------------------------------------------------
module lssg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH):0]     count_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- design/lssg_front.sv -----
// ----------------------------------------------------------------------------
// lssg_front: request intake.
// Accepts a color request, works out the per-channel step of each of the
// three ramps and holds the classified record until the queue takes it.
// ----------------------------------------------------------------------------
module lssg_front import lssg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t item_i,
  output logic full_o,
  output logic job_valid_o,
  output job_t job_o,
  input  logic job_ready_i
);

  logic valid_q, valid_d;
  job_t job_q, job_d;
  logic accept;

  assign full_o      = valid_q && !job_ready_i;
  assign accept      = push_i && !full_o;
  assign job_valid_o = valid_q;
  assign job_o       = job_q;

  // Unpack the colors and classify each ramp channel as rising or falling.
  always_comb begin
    int nxt;
    job_d.col[0] = {item_i.a_blue, item_i.a_green, item_i.a_red};
    job_d.col[1] = {item_i.b_blue, item_i.b_green, item_i.b_red};
    job_d.col[2] = {item_i.c_blue, item_i.c_green, item_i.c_red};
    for (int r = 0; r < NUM_COLORS; r++) begin
      // The last ramp wraps from the third color back to the first.
      nxt = (r == NUM_COLORS - 1) ? 0 : r + 1;
      for (int c = 0; c < NUM_CH; c++) begin
        job_d.rmp[r][c].neg = job_d.col[nxt][c] < job_d.col[r][c];
        job_d.rmp[r][c].mag = job_d.rmp[r][c].neg ?
                              job_d.col[r][c] - job_d.col[nxt][c] :
                              job_d.col[nxt][c] - job_d.col[r][c];
      end
    end
  end

  assign valid_d = accept || (valid_q && !job_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

endmodule

// ----- design/lssg_pixel.sv -----
// ----------------------------------------------------------------------------
// lssg_pixel: pixel engine.
// Walks the strip one position per cycle for the current request, while the output
// queue has room, and runs each position through a five-stage datapath: segment
// lookup, products, numerator and reciprocal, reciprocal multiply, and remainder correction.
// ----------------------------------------------------------------------------
module lssg_pixel import lssg_pkg::*; #(
  parameter int unsigned STRIP_LEN = STRIP_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bounds_t              bound_i,
  input  logic                 job_valid_i,
  input  job_t                 job_i,
  output logic                 job_pop_o,
  input  logic [OUT_CNT_W-1:0] fifo_count_i,
  output logic                 px_valid_o,
  output pixel_t               px_o
);

  localparam int unsigned STAGES = 5;
  localparam int unsigned CRED_W = $clog2(OUT_DEPTH + STAGES) + 1;

  // Sequencer state.
  logic             busy_q, busy_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  job_t             job_q;
  logic             issue, is_last, credit_ok;
  logic [STAGES-1:0] stage_v;

  // Only start a position when the output queue has room for everything
  // already in the datapath plus this one.
  assign credit_ok = (CRED_W'(fifo_count_i) + CRED_W'($countones(stage_v)))
                     < CRED_W'(OUT_DEPTH);
  assign issue     = busy_q && credit_ok;
  assign is_last   = (idx_q == IDX_W'(STRIP_LEN - 1));
  assign job_pop_o = job_valid_i && (!busy_q || (issue && is_last));

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (issue) begin
      idx_d = idx_q + 1'b1;
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (job_pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
  end

  // Segment lookup: the first boundary above the position wins.
  logic [SEG_W-1:0]   seg;
  logic               found;
  logic [BOUND_W-1:0] pos, seg_start, seg_end;

  assign pos = BOUND_W'(idx_q);

  always_comb begin
    seg   = '0;
    found = 1'b0;
    for (int j = 0; j < NUM_BOUNDS; j++) begin
      if (pos < bound_i[j] && !found) begin
        seg   = SEG_W'(j);
        found = 1'b1;
      end
    end
  end

  // A ramp starts at the boundary just below its own.
  assign seg_start = bound_i[{seg[SEG_W-1:1], 1'b0}];
  assign seg_end   = bound_i[seg];

  // Stage 1: classification.
  logic                       s1_v;
  logic [IDX_W-1:0]           s1_idx;
  logic                       s1_last, s1_wr, s1_ramp;
  color_t                     s1_col;
  ramp_t [NUM_CH-1:0]         s1_rmp;
  logic [BOUND_W-1:0]         s1_k, s1_len;

  always_ff @(posedge clk_i) begin
    s1_idx  <= idx_q;
    s1_last <= is_last;
    s1_wr   <= found;
    s1_ramp <= seg[0];
    s1_col  <= job_q.col[seg[SEG_W-1:1]];
    s1_rmp  <= job_q.rmp[seg[SEG_W-1:1]];
    s1_k    <= pos - seg_start;
    s1_len  <= seg_end - seg_start;
  end

  // Stage 2: start times length and offset times step.
  logic                       s2_v;
  logic [IDX_W-1:0]           s2_idx;
  logic                       s2_last, s2_wr, s2_ramp;
  color_t                     s2_col;
  logic [BOUND_W-1:0]         s2_len;
  logic [NUM_CH-1:0]          s2_neg;
  logic [NUM_CH-1:0][PROD_W-1:0] s2_sl, s2_km;

  always_ff @(posedge clk_i) begin
    s2_idx  <= s1_idx;
    s2_last <= s1_last;
    s2_wr   <= s1_wr;
    s2_ramp <= s1_ramp;
    s2_col  <= s1_col;
    s2_len  <= s1_len;
    for (int c = 0; c < NUM_CH; c++) begin
      s2_neg[c] <= s1_rmp[c].neg;
      s2_sl[c]  <= PROD_W'(s1_col[c]) * PROD_W'(s1_len);
      s2_km[c]  <= PROD_W'(s1_k) * PROD_W'(s1_rmp[c].mag);
    end
  end

  // Stage 3: numerator, never negative inside a ramp, and the reciprocal.
  logic                       s3_v;
  logic [IDX_W-1:0]           s3_idx;
  logic                       s3_last, s3_wr, s3_ramp;
  color_t                     s3_col;
  logic [BOUND_W-1:0]         s3_len;
  logic [RECIP_W-1:0]         s3_recip;
  logic [NUM_CH-1:0][PROD_W-1:0] s3_num;

  always_ff @(posedge clk_i) begin
    s3_idx   <= s2_idx;
    s3_last  <= s2_last;
    s3_wr    <= s2_wr;
    s3_ramp  <= s2_ramp;
    s3_col   <= s2_col;
    s3_len   <= s2_len;
    s3_recip <= RECIP_TAB[s2_len];
    for (int c = 0; c < NUM_CH; c++) begin
      s3_num[c] <= s2_neg[c] ? s2_sl[c] - s2_km[c] : s2_sl[c] + s2_km[c];
    end
  end

  // Stage 4: quotient estimate, at most one below the true quotient.
  logic                       s4_v;
  logic [IDX_W-1:0]           s4_idx;
  logic                       s4_last, s4_wr, s4_ramp;
  color_t                     s4_col;
  logic [BOUND_W-1:0]         s4_len;
  logic [NUM_CH-1:0][PROD_W-1:0] s4_num;
  logic [NUM_CH-1:0][CH_W-1:0]   s4_qe;
  logic [NUM_CH-1:0][MUL_W-1:0]  prod;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c] = MUL_W'(s3_num[c]) * MUL_W'(s3_recip);
    end
  end

  always_ff @(posedge clk_i) begin
    s4_idx  <= s3_idx;
    s4_last <= s3_last;
    s4_wr   <= s3_wr;
    s4_ramp <= s3_ramp;
    s4_col  <= s3_col;
    s4_len  <= s3_len;
    s4_num  <= s3_num;
    for (int c = 0; c < NUM_CH; c++) begin
      s4_qe[c] <= prod[c][RECIP_SHIFT +: CH_W];
    end
  end

  // Stage 5: correct the estimate from its remainder and pick the color.
  logic                        s5_v;
  pixel_t                      px_q;
  logic [NUM_CH-1:0][PROD_W-1:0] rem;
  logic [NUM_CH-1:0][CH_W-1:0]   chan;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rem[c] = s4_num[c] - PROD_W'(PROD_W'(s4_qe[c]) * PROD_W'(s4_len));
      if (!s4_wr) begin
        chan[c] = '0;
      end else if (s4_ramp) begin
        chan[c] = (rem[c] >= PROD_W'(s4_len)) ? s4_qe[c] + 1'b1 : s4_qe[c];
      end else begin
        chan[c] = s4_col[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    px_q.pixel_index <= s4_idx;
    px_q.pix_red     <= chan[0];
    px_q.pix_green   <= chan[1];
    px_q.pix_blue    <= chan[2];
    px_q.written     <= s4_wr;
    px_q.last_pixel  <= s4_last;
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
    end
  end

  assign stage_v    = {s5_v, s4_v, s3_v, s2_v, s1_v};
  assign px_valid_o = s5_v;
  assign px_o       = px_q;

endmodule

// ----- design/led_strip_segment_gradient.sv -----
// ----------------------------------------------------------------------------
// led_strip_segment_gradient: six-segment color gradient for an LED strip.
// Each request carries three colors A, B and C; the block answers with one
// pixel per strip position, solid or linearly ramped per the six boundaries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through push/full and are taken when push is high and
//   full is low. Pixels leave through empty/pop in strip order, index 0 to
//   STRIP_LEN-1, the last one marked by last_pixel.
//   The six boundary registers are written through cfg_we_i/cfg_idx_i/
//   cfg_data_i; the user must write them only while no request is in flight,
//   which the block itself does not enforce; indexes past the list are ignored.
//   Throughput: one pixel per cycle while the output queue has room; a request
//   spans STRIP_LEN positions (64 by default) of the pixel engine's position counter.
//   The intake holds the next request and a two-entry queue, so new requests
//   are taken while the current one is still being drawn.
//   Path: a taken request passes the intake register, the request queue and the
//   engine's job register, then the five-stage ramp datapath delivers one a cycle.
//   When the receiver stops popping, the eight-entry output queue fills and
//   the engine pauses; nothing is lost or repeated.
//   Reset clears all boundaries to zero and empties every queue.
// ----------------------------------------------------------------------------
module led_strip_segment_gradient import lssg_pkg::*; #(
  parameter int unsigned STRIP_LEN = STRIP_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request side.
  input  logic                 push,
  output logic                 full,
  input  cmd_t                 in_item_i,
  // Pixel side.
  output logic                 empty,
  input  logic                 pop,
  output pixel_t               out_item_o,
  // Boundary registers.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BOUND_W-1:0]   cfg_data_i
);

  // Boundary registers.
  bounds_t bound_q, bound_d;

  always_comb begin
    bound_d = bound_q;
    if (cfg_we_i && cfg_idx_i <= REG_RAMP_CA_END) begin
      bound_d[cfg_idx_i] = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= '0;
    end else begin
      bound_q <= bound_d;
    end
  end

  // Intake and request queue.
  logic job_valid, cmd_full, cmd_empty, job_pop;
  job_t job_front, job_queued;

  lssg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .job_valid_o (job_valid),
    .job_o       (job_front),
    .job_ready_i (!cmd_full)
  );

  lssg_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .wdata_i (job_front),
    .full_o  (cmd_full),
    .pop_i   (job_pop),
    .rdata_o (job_queued),
    .empty_o (cmd_empty),
    .count_o ()
  );

  // Pixel engine.
  logic                 px_valid, out_full;
  pixel_t               px;
  logic [OUT_CNT_W-1:0] out_count;

  lssg_pixel #(
    .STRIP_LEN (STRIP_LEN)
  ) u_pixel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bound_i      (bound_q),
    .job_valid_i  (!cmd_empty),
    .job_i        (job_queued),
    .job_pop_o    (job_pop),
    .fifo_count_i (out_count),
    .px_valid_o   (px_valid),
    .px_o         (px)
  );

  // Output queue.
  lssg_fifo #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (px_valid),
    .wdata_i (px),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty),
    .count_o (out_count)
  );

  // The credit check must keep every finished pixel from meeting a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) px_valid |-> !out_full)
    else $error("pixel arrived at a full output queue");

  // A pixel past the last boundary carries no color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.written) |->
      (out_item_o.pix_red == '0 && out_item_o.pix_green == '0 &&
       out_item_o.pix_blue == '0))
    else $error("unwritten pixel carries a color");

  // The end marker sits on the final strip position only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.last_pixel) |->
      (out_item_o.pixel_index == IDX_W'(STRIP_LEN - 1)))
    else $error("last pixel marker on wrong index");

  // The engine takes a request only from a non-empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !cmd_empty)
    else $error("request taken from an empty queue");

endmodule

// ----- dv/tb_led_strip_segment_gradient.sv -----
// ----------------------------------------------------------------------------
// tb_led_strip_segment_gradient: self-checking bench for the segment gradient.
// Requests of three colors go in through push/full under several boundary
// settings and idling mixes. Every accepted request is expanded into the full
// strip of expected pixels, and each popped pixel is compared with the oldest.
// ----------------------------------------------------------------------------
module tb_led_strip_segment_gradient import lssg_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STRIP_PIXELS = STRIP_LEN_DEF;
  localparam int unsigned DRAIN_EVERY  = 45;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(NUM_BOUNDS);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 push       = 1'b0;
  logic                 full;
  cmd_t                 in_item_i  = '0;
  logic                 empty;
  logic                 pop        = 1'b0;
  pixel_t               out_item_o;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [BOUND_W-1:0]   cfg_data_i = '0;

  // Bench state: requests waiting to go out, pixels still owed by the block.
  cmd_t        pending_reqs[$];
  pixel_t      pixels_due[$];
  bounds_t     strip_bounds = '0;
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned reqs_taken = 0;
  int unsigned mismatches = 0;
  bit          draining = 1'b0;
  bit          req_taken;

  led_strip_segment_gradient uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Prints one line for a mismatch and counts it.
  task automatic flag_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  // Expected pixel at one strip position for the current boundaries.
  function automatic pixel_t predict_pixel(cmd_t req, int unsigned idx);
    pixel_t      px;
    logic [23:0] col[3];
    int          seg;
    int          src;
    int          dst;
    int          seg_start;
    int          seg_len;
    int          ofs;
    int          s;
    int          e;
    col[0] = {req.a_red, req.a_green, req.a_blue};
    col[1] = {req.b_red, req.b_green, req.b_blue};
    col[2] = {req.c_red, req.c_green, req.c_blue};
    seg = -1;
    // First boundary above the position selects the segment.
    for (int j = 0; j < NUM_BOUNDS; j++) begin
      if (seg < 0 && idx < strip_bounds[j]) seg = j;
    end
    px             = '0;
    px.pixel_index = IDX_W'(idx);
    px.last_pixel  = (idx == STRIP_PIXELS - 1);
    px.written     = (seg >= 0);
    if (seg >= 0) begin
      src = seg / 2;
      dst = (src + 1) % NUM_COLORS;
      seg_start = (seg > 0) ? int'(strip_bounds[seg-1]) : 0;
      seg_len   = int'(strip_bounds[seg]) - seg_start;
      ofs       = int'(idx) - seg_start;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s = int'(col[src][23-8*ch -: 8]);
        e = int'(col[dst][23-8*ch -: 8]);
        // Odd segments ramp; the numerator never goes negative.
        if (seg % 2 == 1) s = (s * seg_len + ofs * (e - s)) / seg_len;
        case (ch)
          0:       px.pix_red   = CH_W'(s);
          1:       px.pix_green = CH_W'(s);
          default: px.pix_blue  = CH_W'(s);
        endcase
      end
    end
    return px;
  endfunction

  // Expands one accepted request into the pixels of the whole strip.
  task automatic queue_strip(input cmd_t req);
    for (int unsigned i = 0; i < STRIP_PIXELS; i++) pixels_due.push_back(predict_pixel(req, i));
  endtask

  // Compares one popped pixel with the oldest expected one.
  task automatic check_pixel(input pixel_t got);
    pixel_t want;
    if (pixels_due.size() == 0) begin
      flag_mismatch($sformatf("pixel %0d arrived with no request outstanding",
                              got.pixel_index));
    end else begin
      want = pixels_due.pop_front();
      if (got.pixel_index !== want.pixel_index)
        flag_mismatch($sformatf("pixel_index got %0d want %0d",
                                got.pixel_index, want.pixel_index));
      if (got.pix_red !== want.pix_red)
        flag_mismatch($sformatf("pixel %0d red got %0d want %0d",
                                want.pixel_index, got.pix_red, want.pix_red));
      if (got.pix_green !== want.pix_green)
        flag_mismatch($sformatf("pixel %0d green got %0d want %0d",
                                want.pixel_index, got.pix_green, want.pix_green));
      if (got.pix_blue !== want.pix_blue)
        flag_mismatch($sformatf("pixel %0d blue got %0d want %0d",
                                want.pixel_index, got.pix_blue, want.pix_blue));
      if (got.written !== want.written)
        flag_mismatch($sformatf("pixel %0d written got %b want %b",
                                want.pixel_index, got.written, want.written));
      if (got.last_pixel !== want.last_pixel)
        flag_mismatch($sformatf("pixel %0d last_pixel got %b want %b",
                                want.pixel_index, got.last_pixel, want.last_pixel));
    end
  endtask

  // Request driver: takes the head of the pending queue, idles at random and
  // now and then holds off until the block has delivered everything.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      in_item_i <= '0;
    end else begin
      req_taken = push && !full;
      if (req_taken) begin
        queue_strip(in_item_i);
        void'(pending_reqs.pop_front());
        reqs_taken++;
        if (reqs_taken % DRAIN_EVERY == 0) draining = 1'b1;
      end
      if (draining && pixels_due.size() == 0) draining = 1'b0;
      if (push && !req_taken) begin
        // The offered request stays on the port until it is taken.
      end else if (pending_reqs.size() != 0 && !draining &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        push      <= 1'b1;
        in_item_i <= pending_reqs[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Pixel monitor: checks each popped pixel and stalls pop at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_pixel(out_item_o);
      pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end
  end

  // Waits until every request is out and every pixel is back, then settles.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || pixels_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BOUND_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx < NUM_BOUNDS) strip_bounds[idx] = val;
  endtask

  // Loads all six boundaries once the block is idle; the spare indexes get
  // junk that the block must ignore.
  task automatic set_boundaries(input int b0, b1, b2, b3, b4, b5);
    wait_drained();
    write_reg(REG_SPARE_LO, BOUND_W'($urandom));
    write_reg(REG_SOLID_A_END, BOUND_W'(b0));
    write_reg(REG_RAMP_AB_END, BOUND_W'(b1));
    write_reg(REG_SOLID_B_END, BOUND_W'(b2));
    write_reg(REG_RAMP_BC_END, BOUND_W'(b3));
    write_reg(REG_SOLID_C_END, BOUND_W'(b4));
    write_reg(REG_RAMP_CA_END, BOUND_W'(b5));
    write_reg(REG_SPARE_HI, BOUND_W'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random boundaries: mostly an ordered layout on the strip, sometimes
  // arbitrary values or values pushed to the ends of the range.
  task automatic random_boundaries();
    int b[6];
    case ($urandom_range(0, 7))
      0: foreach (b[j]) b[j] = $urandom_range(0, 127);
      1: foreach (b[j]) begin
        case ($urandom_range(0, 2))
          0:       b[j] = 0;
          1:       b[j] = STRIP_PIXELS;
          default: b[j] = 127;
        endcase
      end
      default: begin
        foreach (b[j]) b[j] = $urandom_range(0, STRIP_PIXELS);
        b.sort();
      end
    endcase
    set_boundaries(b[0], b[1], b[2], b[3], b[4], b[5]);
  endtask

  function automatic cmd_t tri_cmd(input logic [23:0] a, b, c);
    return cmd_t'({a, b, c});
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom);
    endcase
  endfunction

  task automatic random_reqs(input int unsigned n);
    cmd_t req;
    repeat (n) begin
      for (int j = 0; j < 9; j++) req[8*j +: 8] = rand_chan();
      pending_reqs.push_back(req);
    end
  endtask

  // Run sequence: directed layouts first, then random ones under each idling mix.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset boundaries are all zero, so no pixel is written.
    pending_reqs.push_back(tri_cmd(24'h000000, 24'h000000, 24'h000000));
    pending_reqs.push_back(tri_cmd(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));

    // Ordered layout with all six segments and a tail past the last boundary.
    set_boundaries(10, 20, 30, 40, 50, 60);
    pending_reqs.push_back(tri_cmd(24'h000000, 24'hFFFFFF, 24'h000000));
    pending_reqs.push_back(tri_cmd(24'hFFFFFF, 24'h000000, 24'hFFFFFF));
    pending_reqs.push_back(tri_cmd(24'hFF00FF, 24'h00FF00, 24'h808080));
    pending_reqs.push_back(tri_cmd(24'h123456, 24'hFEDCBA, 24'h0F0F0F));

    // Boundaries out of order leave some segments empty.
    set_boundaries(40, 10, 50, 20, 127, 30);
    pending_reqs.push_back(tri_cmd(24'h00FF80, 24'hFF0040, 24'h7F7F7F));
    pending_reqs.push_back(tri_cmd(24'hA5A5A5, 24'h5A5A5A, 24'hC3C3C3));

    // One long ramp that runs past the end of the strip.
    set_boundaries(0, 127, 127, 127, 127, 127);
    pending_reqs.push_back(tri_cmd(24'h000000, 24'hFFFFFF, 24'h000000));
    pending_reqs.push_back(tri_cmd(24'hFFFFFF, 24'h000000, 24'hFFFFFF));

    // One-pixel segments, so each ramp has length one.
    set_boundaries(1, 2, 3, 4, 5, 6);
    pending_reqs.push_back(tri_cmd(24'h112233, 24'h445566, 24'h778899));
    pending_reqs.push_back(tri_cmd(24'hFFFFFF, 24'h000000, 24'hFF00FF));

    // Wrap-around ramp from the third color back to the first over the strip.
    set_boundaries(0, 0, 0, 0, 0, STRIP_PIXELS);
    pending_reqs.push_back(tri_cmd(24'h000000, 24'h123456, 24'hFFFFFF));
    pending_reqs.push_back(tri_cmd(24'hFFFFFF, 24'h654321, 24'h000000));

    // Solid first color, both at the strip length and at the register maximum.
    set_boundaries(STRIP_PIXELS, STRIP_PIXELS, STRIP_PIXELS, STRIP_PIXELS,
                   STRIP_PIXELS, STRIP_PIXELS);
    pending_reqs.push_back(tri_cmd(24'hFFFFFF, 24'h000000, 24'h000000));
    set_boundaries(127, 127, 127, 127, 127, 127);
    pending_reqs.push_back(tri_cmd(24'h807F01, 24'h000000, 24'hFFFFFF));

    // Full-strip ramp from the first to the second color.
    set_boundaries(0, STRIP_PIXELS, STRIP_PIXELS, STRIP_PIXELS, STRIP_PIXELS, STRIP_PIXELS);
    pending_reqs.push_back(tri_cmd(24'hFFFFFF, 24'h000000, 24'h55AA55));
    pending_reqs.push_back(tri_cmd(24'h000000, 24'hFFFFFF, 24'hAA55AA));

    // Random requests under each idling mix, two layouts per mix.
    for (int mode = 0; mode < 4; mode++) begin
      for (int part = 0; part < 2; part++) begin
        random_boundaries();
        case (mode)
          0:       begin send_idle_pct = 0;  pop_stall_pct = 0;  end
          1:       begin send_idle_pct = 63; pop_stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  pop_stall_pct = 63; end
          default: begin send_idle_pct = 28; pop_stall_pct = 28; end
        endcase
        random_reqs(37);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pixels_due.size() != 0)
      flag_mismatch($sformatf("%0d pixels never delivered", pixels_due.size()));
    if (mismatches == 0) begin
      $display("led_strip_segment_gradient verification clean");
    end else begin
      $display("led_strip_segment_gradient verification failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("led_strip_segment_gradient verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lssg_pkg.sv
design/lssg_fifo.sv
design/lssg_front.sv
design/lssg_pixel.sv
design/led_strip_segment_gradient.sv
dv/tb_led_strip_segment_gradient.sv
